>>> sv/wmm_pkg.sv
// ----------------------------------------------------------------------------
// wmm_pkg: shared types and constants of the waveform min/max/abs-mean cache
// Sizes, register indexes, controller states, the command and status bundles
// and the sqrt-two block length table.
// ----------------------------------------------------------------------------
package wmm_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 16;
  localparam int CH_BITS      = 3;
  localparam int IDX_BITS     = CH_BITS + 1;
  localparam int ENTRIES      = 2 * MAX_CHANNELS;
  localparam int SUM_BITS     = 29;
  localparam int CNT_BITS     = 13;
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);
  localparam int POW_BITS     = 4;
  localparam int CC_BITS      = 4;
  localparam int CFG_W        = 4;
  localparam int IN_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = CH_BITS + 3 * SAMPLE_BITS;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [POW_BITS-1:0] MAX_POWER     = 4'd12;
  localparam logic [POW_BITS-1:0] POWER_RESET   = 4'd8;
  localparam logic [CC_BITS-1:0]  CHANNEL_RESET = 4'd2;
  localparam logic [CC_BITS-1:0]  CC_MAX        = CC_BITS'(MAX_CHANNELS);

  // configuration register indexes
  localparam logic REG_CACHE_POWER   = 1'b0;
  localparam logic REG_CHANNEL_COUNT = 1'b1;

  // input item kinds
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;

  // block kinds
  localparam logic KIND_POW2  = 1'b0;
  localparam logic KIND_SQRT2 = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD1,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               upd;
    logic               upd_kind;
    logic               use_in;
    logic               step;
    logic               end_frame;
    logic               pos_clear;
    logic               div_start;
    logic               out_load;
    logic               out_last;
    logic               clear_count;
    logic               kind;
    logic [CH_BITS-1:0] ech;
  } cmd_t;

  typedef struct packed {
    logic       frame_done;
    logic       pos_nz;
    logic [1:0] inc_hit;
    logic [1:0] inc_nz;
    logic [1:0] cur_nz;
    logic       ch_last;
    logic       div_busy;
    logic       out_free;
  } sts_t;

  // floor(2^p * sqrt(2) + 0.01)
  function automatic logic [CNT_BITS-1:0] sqrt2_len(input logic [POW_BITS-1:0] p);
    logic [CNT_BITS-1:0] len;
    case (p)
      4'd0:    len = 13'd1;
      4'd1:    len = 13'd2;
      4'd2:    len = 13'd5;
      4'd3:    len = 13'd11;
      4'd4:    len = 13'd22;
      4'd5:    len = 13'd45;
      4'd6:    len = 13'd90;
      4'd7:    len = 13'd181;
      4'd8:    len = 13'd362;
      4'd9:    len = 13'd724;
      4'd10:   len = 13'd1448;
      4'd11:   len = 13'd2896;
      default: len = 13'd5792;
    endcase
    return len;
  endfunction

endpackage

>>> sv/wmm_div.sv
// ----------------------------------------------------------------------------
// wmm_div: restoring divider
// One quotient bit per cycle; sum of magnitudes over frame count.
// ----------------------------------------------------------------------------
module wmm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wmm_pkg::SUM_BITS-1:0]  dividend,
  input  logic [wmm_pkg::CNT_BITS-1:0]  divisor,
  output logic                          busy,
  output logic [wmm_pkg::SUM_BITS-1:0]  quotient
);

  logic                              busy_r;
  logic [wmm_pkg::DIV_CNT_BITS-1:0]  cnt_r;
  logic [wmm_pkg::CNT_BITS-1:0]      rem_r;
  logic [wmm_pkg::CNT_BITS-1:0]      rem_nxt;
  logic [wmm_pkg::CNT_BITS-1:0]      dvs_r;
  logic [wmm_pkg::SUM_BITS-1:0]      quo_r;
  logic [wmm_pkg::CNT_BITS:0]        trial;
  logic [wmm_pkg::CNT_BITS:0]        diff;
  logic                              fits;

  always_comb begin
    trial   = {rem_r, quo_r[wmm_pkg::SUM_BITS-1]};
    diff    = trial - {1'b0, dvs_r};
    fits    = trial >= {1'b0, dvs_r};
    rem_nxt = fits ? diff[wmm_pkg::CNT_BITS-1:0] : trial[wmm_pkg::CNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= wmm_pkg::DIV_CNT_BITS'(wmm_pkg::SUM_BITS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == wmm_pkg::DIV_CNT_BITS'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[wmm_pkg::SUM_BITS-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

>>> sv/wmm_dp.sv
// ----------------------------------------------------------------------------
// wmm_dp: datapath of the min/max/abs-mean cache
// Config registers, per-entry summaries, frame counters, divider, result reg.
// ----------------------------------------------------------------------------
module wmm_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic [wmm_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [wmm_pkg::SAMPLE_BITS-1:0]  in_sample,
  input  wmm_pkg::cmd_t                    cmd,
  output wmm_pkg::sts_t                    sts,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [wmm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast
);

  localparam int SB = wmm_pkg::SAMPLE_BITS;

  logic [wmm_pkg::POW_BITS-1:0]  power_r;
  logic [wmm_pkg::CC_BITS-1:0]   chans_r;
  logic [wmm_pkg::POW_BITS-1:0]  eff_pow;
  logic [wmm_pkg::CC_BITS-1:0]   eff_cc;

  logic [wmm_pkg::CH_BITS-1:0]   pos_r;
  logic [wmm_pkg::CH_BITS-1:0]   ch;
  logic [wmm_pkg::CNT_BITS-1:0]  fc_r [2];
  logic [wmm_pkg::CNT_BITS-1:0]  fc_inc [2];
  logic [wmm_pkg::CNT_BITS-1:0]  blk_len [2];

  logic signed [SB-1:0]          min_r [wmm_pkg::ENTRIES];
  logic signed [SB-1:0]          max_r [wmm_pkg::ENTRIES];
  logic [wmm_pkg::SUM_BITS-1:0]  sum_r [wmm_pkg::ENTRIES];

  logic signed [SB-1:0]          samp_r;
  logic signed [SB-1:0]          samp;
  logic signed [SB:0]            samp_ext;
  logic [SB:0]                   mag;
  logic [wmm_pkg::IDX_BITS-1:0]  idx;

  logic                          div_busy;
  logic [wmm_pkg::SUM_BITS-1:0]  quotient;

  logic                          ov_r;
  logic                          okind_r;
  logic                          olast_r;
  logic [wmm_pkg::CH_BITS-1:0]   och_r;
  logic [SB-1:0]                 olow_r;
  logic [SB-1:0]                 ohigh_r;
  logic [SB-1:0]                 omean_r;

  // effective register values
  always_comb begin
    eff_pow = (power_r > wmm_pkg::MAX_POWER) ? wmm_pkg::MAX_POWER : power_r;
    if (chans_r == '0) begin
      eff_cc = wmm_pkg::CC_BITS'(1);
    end else if (chans_r > wmm_pkg::CC_MAX) begin
      eff_cc = wmm_pkg::CC_MAX;
    end else begin
      eff_cc = chans_r;
    end
    blk_len[0] = wmm_pkg::CNT_BITS'(1) << eff_pow;
    blk_len[1] = wmm_pkg::sqrt2_len(eff_pow);
  end

  always_comb begin
    ch       = ({1'b0, pos_r} < eff_cc) ? pos_r : '0;
    samp     = cmd.use_in ? $signed(in_sample) : samp_r;
    samp_ext = {samp[SB-1], samp};
    mag      = samp[SB-1] ? (SB+1)'(0) - samp_ext : samp_ext;
    idx      = cmd.upd ? {ch, cmd.upd_kind} : {cmd.ech, cmd.kind};
    for (int k = 0; k < 2; k++) begin
      fc_inc[k]      = fc_r[k] + 1'b1;
      sts.inc_hit[k] = fc_inc[k] >= blk_len[k];
      sts.inc_nz[k]  = fc_inc[k] != '0;
      sts.cur_nz[k]  = fc_r[k] != '0;
    end
    sts.frame_done = (wmm_pkg::CC_BITS'(ch) + 1'b1) >= eff_cc;
    sts.pos_nz     = pos_r != '0;
    sts.ch_last    = wmm_pkg::CC_BITS'(cmd.ech) == (eff_cc - 1'b1);
    sts.div_busy   = div_busy;
    sts.out_free   = !ov_r || out_tready;
  end

  // configuration, position and frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r <= wmm_pkg::POWER_RESET;
      chans_r <= wmm_pkg::CHANNEL_RESET;
      pos_r   <= '0;
      fc_r[0] <= '0;
      fc_r[1] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          wmm_pkg::REG_CACHE_POWER:   power_r <= cfg_wdata;
          wmm_pkg::REG_CHANNEL_COUNT: chans_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.pos_clear) begin
        pos_r <= '0;
      end else if (cmd.step) begin
        pos_r <= sts.frame_done ? '0 : ch + 1'b1;
      end
      if (cmd.end_frame) begin
        fc_r[0] <= fc_inc[0];
        fc_r[1] <= fc_inc[1];
      end
      if (cmd.clear_count) begin
        fc_r[cmd.kind] <= '0;
      end
    end
  end

  // per-channel, per-kind summaries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wmm_pkg::ENTRIES; i++) begin
        min_r[i] <= '0;
        max_r[i] <= '0;
        sum_r[i] <= '0;
      end
    end else if (cmd.upd) begin
      if (samp < min_r[idx]) min_r[idx] <= samp;
      if (samp > max_r[idx]) max_r[idx] <= samp;
      sum_r[idx] <= sum_r[idx] + wmm_pkg::SUM_BITS'(mag);
    end else if (cmd.out_load) begin
      min_r[idx] <= '0;
      max_r[idx] <= '0;
      sum_r[idx] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.use_in) samp_r <= $signed(in_sample);
  end

  wmm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r[idx]),
    .divisor  (fc_r[cmd.kind]),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      okind_r <= cmd.kind;
      olast_r <= cmd.out_last;
      och_r   <= cmd.ech;
      olow_r  <= min_r[idx];
      ohigh_r <= max_r[idx];
      omean_r <= quotient[SB-1:0];
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {(wmm_pkg::OUT_TDATA_W - wmm_pkg::OUT_FIELDS_W)'(0),
                       omean_r, ohigh_r, olow_r, och_r};

endmodule

>>> sv/wmm_ctrl.sv
// ----------------------------------------------------------------------------
// wmm_ctrl: controller of the min/max/abs-mean cache
// Sequences summary updates, frame ends and the per-channel result pass.
// ----------------------------------------------------------------------------
module wmm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_func,
  output logic           in_tready,
  input  wmm_pkg::sts_t  sts,
  output wmm_pkg::cmd_t  cmd
);

  wmm_pkg::state_t             state_r;
  wmm_pkg::state_t             state_nxt;
  // pending emissions: full kind 0, full kind 1, flushed kind 0, flushed kind 1
  logic [3:0]                  pend_r;
  logic [3:0]                  pend_nxt;
  logic [3:0]                  pend_rest;
  logic [1:0]                  slot;
  logic [wmm_pkg::CH_BITS-1:0] ech_r;
  logic [wmm_pkg::CH_BITS-1:0] ech_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wmm_pkg::ST_IDLE;
      pend_r  <= '0;
      ech_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      ech_r   <= ech_nxt;
    end
  end

  always_comb begin
    if (pend_r[0])      slot = 2'd0;
    else if (pend_r[1]) slot = 2'd1;
    else if (pend_r[2]) slot = 2'd2;
    else                slot = 2'd3;
    pend_rest       = pend_r;
    pend_rest[slot] = 1'b0;

    state_nxt = state_r;
    pend_nxt  = pend_r;
    ech_nxt   = ech_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.kind  = slot[0];
    cmd.ech   = ech_r;

    case (state_r)
      wmm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        ech_nxt   = '0;
        if (in_tvalid) begin
          if (in_func == wmm_pkg::FUNC_SAMPLE) begin
            cmd.upd      = 1'b1;
            cmd.upd_kind = wmm_pkg::KIND_POW2;
            cmd.use_in   = 1'b1;
            state_nxt    = wmm_pkg::ST_UPD1;
          end else begin
            cmd.pos_clear = 1'b1;
            if (sts.pos_nz) begin
              // close the open frame, then flush what did not complete
              cmd.end_frame = 1'b1;
              pend_nxt = {~sts.inc_hit & sts.inc_nz, sts.inc_hit};
            end else begin
              pend_nxt = {sts.cur_nz, 2'b00};
            end
            state_nxt = (pend_nxt != '0) ? wmm_pkg::ST_DIV_GO : wmm_pkg::ST_IDLE;
          end
        end
      end
      wmm_pkg::ST_UPD1: begin
        cmd.upd      = 1'b1;
        cmd.upd_kind = wmm_pkg::KIND_SQRT2;
        cmd.step     = 1'b1;
        state_nxt    = wmm_pkg::ST_IDLE;
        if (sts.frame_done) begin
          cmd.end_frame = 1'b1;
          pend_nxt      = {2'b00, sts.inc_hit};
          if (sts.inc_hit != '0) state_nxt = wmm_pkg::ST_DIV_GO;
        end
      end
      wmm_pkg::ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = wmm_pkg::ST_DIV_WAIT;
      end
      wmm_pkg::ST_DIV_WAIT: begin
        if (!sts.div_busy) state_nxt = wmm_pkg::ST_OUT;
      end
      wmm_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = sts.ch_last && (pend_rest == '0);
          if (sts.ch_last) begin
            cmd.clear_count = 1'b1;
            pend_nxt        = pend_rest;
            ech_nxt         = '0;
            state_nxt = (pend_rest != '0) ? wmm_pkg::ST_DIV_GO : wmm_pkg::ST_IDLE;
          end else begin
            ech_nxt   = ech_r + 1'b1;
            state_nxt = wmm_pkg::ST_DIV_GO;
          end
        end
      end
      default: state_nxt = wmm_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> sv/waveform_min_max_absmean_cache_unit.sv
// ----------------------------------------------------------------------------
// waveform_min_max_absmean_cache_unit: min/max/abs-mean waveform decimator
// Keeps per-channel ranges over two block lengths of an interleaved stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one interleaved sample per transfer; in_tuser is the item kind
//           (sample or end-of-stream flush), in_tdata holds the sample. The
//           unit tracks the channel position itself.
//   out_* : one range per transfer; out_tuser is the block kind, out_tlast
//           marks the final range caused by an input transfer.
//   cfg_* : write-only registers; the user must write them only while the unit is idle (not enforced).
// Sequencing: a sample that does not close a block is accepted, then the
//   second summary of its channel is updated. A sample or flush that
//   completes blocks then emits one range per channel for each block kind it
//   ends; each range waits for the shared bit-serial divider (29 quotient
//   bits) that forms the mean absolute value, and is then loaded into the
//   result register.
// Reset clears the configuration to its defaults and all summaries to zero.
// A stalled receiver holds the result register and with it the whole unit;
//   no input is taken until every range of the current item is transferred
//   into the result register.
// ----------------------------------------------------------------------------
module waveform_min_max_absmean_cache_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [wmm_pkg::IN_TDATA_W-1:0]   in_tdata,   // [15:0] sample
  input  logic                             in_tuser,   // [0] func
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [wmm_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [2:0] channel, [18:3] low_value,
                                                       // [34:19] high_value, [50:35] abs_mean
  output logic                             out_tuser,  // [0] block_kind
  output logic                             out_tlast,
  // configuration
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic [wmm_pkg::CFG_W-1:0]        cfg_wdata
);

  wmm_pkg::cmd_t cmd;
  wmm_pkg::sts_t sts;

  // sequence the work of each transfer
  wmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold summaries, counters, divider and the result register
  wmm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_sample  (in_tdata[wmm_pkg::SAMPLE_BITS-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // a sample transfer is never directly followed by another input; its other summary is updated first
  a_sample_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == wmm_pkg::FUNC_SAMPLE) |=> !in_tready)
    else $error("input taken directly after a sample transfer");

  // a flush always returns the channel position to the frame start
  a_flush_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == wmm_pkg::FUNC_FLUSH) |=> !sts.pos_nz)
    else $error("channel position not cleared by flush");

  // no input is taken while a mean is being divided
  a_no_input_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_busy |-> !in_tready)
    else $error("input ready during divide");

endmodule
